>>> rtl/core/vn_pkg.sv
// ----------------------------------------------------------------------------
// vn_pkg
// Shared constants and types for the 3D vector normalizer.
// ----------------------------------------------------------------------------
package vn_pkg;

	localparam int IO_W           = 32;
	localparam int COMP_WIDTH_DEF = 32;
	localparam int UNIT_SHIFT     = 30;
	localparam int QUOT_W         = UNIT_SHIFT + 1;

	typedef struct packed {
		logic load;
		logic step;
	} div_ctrl_t;

endpackage

>>> rtl/core/vector3_normalize.sv
// ----------------------------------------------------------------------------
// vector3_normalize
// Length and unit vector of a signed fixed-point 3D vector: squares summed
// on one shared multiplier, bit-serial square root, three division lanes.
// ----------------------------------------------------------------------------
// a request runs through squaring, the serial root and the 31-step division
//   lanes, then a finish state that drives done
// zero vector: goes from idle straight to the finish state, skipping the rest
// no new request while busy; start is taken in the cycle done shows
// reset clears control state and results; results hold until the next done
// ----------------------------------------------------------------------------
module vector3_normalize #(
	parameter int COMP_WIDTH = vn_pkg::COMP_WIDTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic signed [vn_pkg::IO_W-1:0]   x_in,
	input  logic signed [vn_pkg::IO_W-1:0]   y_in,
	input  logic signed [vn_pkg::IO_W-1:0]   z_in,
	output logic                             done,
	output logic [vn_pkg::IO_W-1:0]          length,
	output logic signed [vn_pkg::IO_W-1:0]   x_unit,
	output logic signed [vn_pkg::IO_W-1:0]   y_unit,
	output logic signed [vn_pkg::IO_W-1:0]   z_unit,
	output logic                             zero_vector
);

	localparam int CW    = COMP_WIDTH;
	localparam int SUM_W = 2 * CW;
	localparam int IO_W  = vn_pkg::IO_W;
	localparam int CNT_W = $clog2(vn_pkg::QUOT_W);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SQUARE,
		ST_ROOT,
		ST_DIV,
		ST_FINISH
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] cnt_q;
	logic             sqrt_go_q;

	logic [CW-1:0]    mag_q [3];
	logic [2:0]       neg_q;
	logic             zero_q;
	logic [SUM_W-1:0] prod_q;
	logic [SUM_W-1:0] sum_q;
	logic [CW-1:0]    len_q;

	logic [IO_W-1:0]  comp_in [3];
	logic [CW-1:0]    raw_d [3];
	logic [CW-1:0]    mag_d [3];
	logic [2:0]       neg_d;
	logic             zero_d;
	logic [CW-1:0]    mag_sel;
	logic [SUM_W-1:0] sq_d;

	logic                      sqrt_done;
	logic [CW-1:0]             sqrt_root;
	vn_pkg::div_ctrl_t         div_ctrl;
	logic [vn_pkg::QUOT_W-1:0] quot [3];
	logic [IO_W-1:0]           quot_ext [3];
	logic [IO_W-1:0]           unit_d [3];

	assign comp_in[0] = x_in;
	assign comp_in[1] = y_in;
	assign comp_in[2] = z_in;

	// magnitude of the low COMP_WIDTH bits, most negative value taken exactly
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			raw_d[i] = comp_in[i][CW-1:0];
			neg_d[i] = raw_d[i][CW-1];
			mag_d[i] = neg_d[i] ? (~raw_d[i] + 1'b1) : raw_d[i];
		end
		zero_d = (raw_d[0] == '0) && (raw_d[1] == '0) && (raw_d[2] == '0);
	end

	always_comb begin
		unique case (cnt_q[1:0])
			2'd0:    mag_sel = mag_q[0];
			2'd1:    mag_sel = mag_q[1];
			default: mag_sel = mag_q[2];
		endcase
	end

	assign sq_d = SUM_W'(mag_sel) * SUM_W'(mag_sel);

	assign div_ctrl.load = (state_q == ST_ROOT) && sqrt_done;
	assign div_ctrl.step = (state_q == ST_DIV);

	vn_sqrt #(
		.CW(CW)
	) u_sqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (sqrt_go_q),
		.radicand(sum_q),
		.done    (sqrt_done),
		.root    (sqrt_root)
	);

	for (genvar g = 0; g < 3; g++) begin : g_lane
		vn_div #(
			.CW(CW)
		) u_div (
			.clk (clk),
			.ctrl(div_ctrl),
			.mag (mag_q[g]),
			.len (len_q),
			.quot(quot[g])
		);

		assign quot_ext[g] = IO_W'(quot[g]);
		assign unit_d[g]   = neg_q[g] ? (~quot_ext[g] + 1'b1) : quot_ext[g];
	end

	assign busy = (state_q != ST_IDLE);

	always_ff @(posedge clk) begin
		if ((state_q == ST_IDLE) && start) begin
			mag_q  <= mag_d;
			neg_q  <= neg_d;
			zero_q <= zero_d;
			sum_q  <= '0;
		end else if (state_q == ST_SQUARE) begin
			if (cnt_q != CNT_W'(3)) begin
				prod_q <= sq_d;
			end
			if (cnt_q != '0) begin
				sum_q <= sum_q + prod_q;
			end
		end else if ((state_q == ST_ROOT) && sqrt_done) begin
			len_q <= sqrt_root;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			sqrt_go_q   <= 1'b0;
			done        <= 1'b0;
			zero_vector <= 1'b0;
			length      <= '0;
			x_unit      <= '0;
			y_unit      <= '0;
			z_unit      <= '0;
		end else begin
			done      <= 1'b0;
			sqrt_go_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						cnt_q   <= '0;
						state_q <= zero_d ? ST_FINISH : ST_SQUARE;
					end
				end
				ST_SQUARE: begin
					if (cnt_q == CNT_W'(3)) begin
						sqrt_go_q <= 1'b1;
						state_q   <= ST_ROOT;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_ROOT: begin
					if (sqrt_done) begin
						cnt_q   <= '0;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (cnt_q == CNT_W'(vn_pkg::QUOT_W - 1)) begin
						state_q <= ST_FINISH;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_FINISH: begin
					done        <= 1'b1;
					zero_vector <= zero_q;
					length      <= zero_q ? '0 : IO_W'(len_q);
					x_unit      <= zero_q ? '0 : $signed(unit_d[0]);
					y_unit      <= zero_q ? '0 : $signed(unit_d[1]);
					z_unit      <= zero_q ? '0 : $signed(unit_d[2]);
					state_q     <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted request did not raise busy");

	a_zero_result: assert property (@(posedge clk) disable iff (!arst_n)
		done && zero_vector |-> length == '0 && x_unit == '0 && y_unit == '0 && z_unit == '0)
		else $error("zero vector result not all zero");

	a_nonzero_len: assert property (@(posedge clk) disable iff (!arst_n)
		done && !zero_vector |-> length != '0)
		else $error("nonzero vector gave zero length");

	a_root_in_state: assert property (@(posedge clk) disable iff (!arst_n)
		sqrt_done |-> state_q == ST_ROOT)
		else $error("square root finished outside root phase");
`endif

endmodule

>>> rtl/core/vn_sqrt.sv
// ----------------------------------------------------------------------------
// vn_sqrt
// Bit-serial integer square root, one root bit per cycle, truncated result.
// ----------------------------------------------------------------------------
module vn_sqrt #(
	parameter int CW = vn_pkg::COMP_WIDTH_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [2*CW-1:0] radicand,
	output logic            done,
	output logic [CW-1:0]   root
);

	localparam int RAD_W = 2 * CW;
	localparam int REM_W = CW + 2;
	localparam int CNT_W = $clog2(CW);

	logic [RAD_W-1:0] rad_q;
	logic [REM_W-1:0] rem_q;
	logic [CW-1:0]    root_q;
	logic [CNT_W-1:0] cnt_q;
	logic             run_q;
	logic             done_q;

	logic [REM_W-1:0] rem_sh;
	logic [REM_W-1:0] trial;
	logic [REM_W-1:0] diff;
	logic             ge;

	// bring down two radicand bits, try root*4+1
	assign rem_sh = {rem_q[REM_W-3:0], rad_q[RAD_W-1 -: 2]};
	assign trial  = {root_q, 2'b01};
	assign ge     = (rem_sh >= trial);
	assign diff   = rem_sh - trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CNT_W'(CW - 1);
			end else if (run_q) begin
				if (cnt_q == '0) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (run_q) begin
			rad_q  <= {rad_q[RAD_W-3:0], 2'b00};
			rem_q  <= ge ? diff : rem_sh;
			root_q <= {root_q[CW-2:0], ge};
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

>>> rtl/core/vn_div.sv
// ----------------------------------------------------------------------------
// vn_div
// Restoring divider lane, one quotient bit per cycle, for mag * 2^30 / len
// where mag does not exceed len.
// ----------------------------------------------------------------------------
module vn_div #(
	parameter int CW = vn_pkg::COMP_WIDTH_DEF
) (
	input  logic                        clk,
	input  vn_pkg::div_ctrl_t           ctrl,
	input  logic [CW-1:0]               mag,
	input  logic [CW-1:0]               len,
	output logic [vn_pkg::QUOT_W-1:0]   quot
);

	logic [CW:0]                rem_q;
	logic [vn_pkg::QUOT_W-1:0]  quot_q;

	logic [CW:0] len_ext;
	logic [CW:0] red;
	logic        ge;

	assign len_ext = {1'b0, len};
	assign ge      = (rem_q >= len_ext);
	assign red     = ge ? (rem_q - len_ext) : rem_q;

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			rem_q  <= {1'b0, mag};
			quot_q <= '0;
		end else if (ctrl.step) begin
			rem_q  <= {red[CW-1:0], 1'b0};
			quot_q <= {quot_q[vn_pkg::QUOT_W-2:0], ge};
		end
	end

	assign quot = quot_q;

endmodule

>>> tb/tb_vector3_normalize.sv
// ----------------------------------------------------------------------------
// tb_vector3_normalize
// Self-checking bench for the 3D vector normalizer. Each accepted request is
// run through a behavioral model of the length and unit vector computation
// and the expectation is queued. Every done strobe is checked field by field
// against the oldest expectation. Directed corner vectors come first, then
// random vectors under several sender idle rates.
// ----------------------------------------------------------------------------
module tb_vector3_normalize;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int IO_W       = vn_pkg::IO_W;
	localparam int UNIT_SHIFT = vn_pkg::UNIT_SHIFT;
	localparam int COMP_W     = vn_pkg::COMP_WIDTH_DEF;
	localparam int LATENCY    = COMP_W + 39;
	localparam int N_RANDOM   = 400;

	typedef struct {
		logic [IO_W-1:0]        len;
		logic signed [IO_W-1:0] ux;
		logic signed [IO_W-1:0] uy;
		logic signed [IO_W-1:0] uz;
		logic                   zero;
	} norm_result_t;

	logic                   clk;
	logic                   arst_n;
	logic                   start;
	logic                   busy;
	logic signed [IO_W-1:0] x_in;
	logic signed [IO_W-1:0] y_in;
	logic signed [IO_W-1:0] z_in;
	logic                   done;
	logic [IO_W-1:0]        length;
	logic signed [IO_W-1:0] x_unit;
	logic signed [IO_W-1:0] y_unit;
	logic signed [IO_W-1:0] z_unit;
	logic                   zero_vector;

	norm_result_t pending_norms[$];
	int           mismatch_count = 0;

	vector3_normalize DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.x_in       (x_in),
		.y_in       (y_in),
		.z_in       (z_in),
		.done       (done),
		.length     (length),
		.x_unit     (x_unit),
		.y_unit     (y_unit),
		.z_unit     (z_unit),
		.zero_vector(zero_vector)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("simulation failed");
		$finish;
	end

	function automatic logic [63:0] comp_magnitude(input logic [IO_W-1:0] raw,
			output logic neg);
		logic [63:0] mask;
		logic [63:0] v;
		mask = (64'd1 << COMP_W) - 64'd1;
		v    = {{(64-IO_W){1'b0}}, raw} & mask;
		neg  = v[COMP_W-1];
		return neg ? ((~v + 64'd1) & mask) : v;
	endfunction

	function automatic logic [63:0] floor_sqrt(input logic [63:0] n);
		logic [63:0] rem;
		logic [63:0] root;
		logic [63:0] b;
		rem  = n;
		root = 64'd0;
		b    = 64'd1 << 62;
		while (b > rem)
			b = b >> 2;
		while (b != 64'd0) begin
			if (rem >= root + b) begin
				rem  = rem - (root + b);
				root = (root >> 1) + b;
			end else begin
				root = root >> 1;
			end
			b = b >> 2;
		end
		return root;
	endfunction

	function automatic norm_result_t normalize_vector(input logic [IO_W-1:0] x,
			input logic [IO_W-1:0] y, input logic [IO_W-1:0] z);
		norm_result_t r;
		logic [63:0]  mag[3];
		logic         neg[3];
		logic [63:0]  sum;
		logic [63:0]  len;
		logic [63:0]  q;
		logic [IO_W-1:0] u[3];
		mag[0] = comp_magnitude(x, neg[0]);
		mag[1] = comp_magnitude(y, neg[1]);
		mag[2] = comp_magnitude(z, neg[2]);
		sum = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
		if (sum == 64'd0) begin
			r.len  = '0;
			r.ux   = '0;
			r.uy   = '0;
			r.uz   = '0;
			r.zero = 1'b1;
			return r;
		end
		len = floor_sqrt(sum);
		for (int i = 0; i < 3; i++) begin
			q = (mag[i] << UNIT_SHIFT) / len;
			if (neg[i])
				q = ~q + 64'd1;
			u[i] = q[IO_W-1:0];
		end
		r.len  = len[IO_W-1:0];
		r.ux   = u[0];
		r.uy   = u[1];
		r.uz   = u[2];
		r.zero = 1'b0;
		return r;
	endfunction

	// drive at the falling edge, hold until taken at a rising edge with busy low
	task automatic send_request(input logic [IO_W-1:0] x, input logic [IO_W-1:0] y,
			input logic [IO_W-1:0] z, input int idle_pct);
		int hold;
		hold = 0;
		if (idle_pct > 0 && $urandom_range(0, 7) == 0)
			hold = $urandom_range(0, LATENCY + 10);
		while (hold > 0 || $urandom_range(0, 99) < idle_pct) begin
			@(negedge clk);
			start = 1'b0;
			if (hold > 0)
				hold--;
		end
		@(negedge clk);
		start = 1'b1;
		x_in  = x;
		y_in  = y;
		z_in  = z;
		do
			@(posedge clk);
		while (busy);
		pending_norms.push_back(normalize_vector(x, y, z));
	endtask

	function automatic logic [IO_W-1:0] rand_component();
		logic [IO_W-1:0] v;
		case ($urandom_range(0, 5))
			0: v = $urandom_range(0, 255);
			1: v = -$urandom_range(0, 255);
			2: begin
				case ($urandom_range(0, 4))
					0: v = {1'b1, {(IO_W-1){1'b0}}};
					1: v = {1'b0, {(IO_W-1){1'b1}}};
					2: v = '0;
					3: v = '1;
					default: v = 1;
				endcase
			end
			3, 4: begin
				v = $urandom >> $urandom_range(0, 31);
				if ($urandom_range(0, 1))
					v = -v;
			end
			default: v = $urandom;
		endcase
		return v;
	endfunction

	task automatic run_random(input int count, input int idle_pct);
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 49) == 0)
				send_request('0, '0, '0, idle_pct);
			else
				send_request(rand_component(), rand_component(), rand_component(), idle_pct);
		end
	endtask

	task automatic test_directed();
		logic [IO_W-1:0] mn;
		logic [IO_W-1:0] mx;
		mn = {1'b1, {(IO_W-1){1'b0}}};
		mx = {1'b0, {(IO_W-1){1'b1}}};
		send_request('0, '0, '0, 0);
		send_request(mn, mn, mn, 0);
		send_request(mx, mx, mx, 0);
		send_request(mn, '0, '0, 0);
		send_request('0, mn, '0, 0);
		send_request('0, '0, mn, 0);
		send_request(mx, mn, '0, 0);
		send_request(1, '0, '0, 0);
		send_request('0, -1, '0, 0);
		send_request('0, '0, -1, 0);
		send_request(1, 1, 1, 0);
		send_request(-1, -1, -1, 0);
		send_request(32'sd3 <<< 16, 32'sd4 <<< 16, '0, 0);
		send_request(mx, 1, -1, 0);
		send_request(mn, mx, 1, 0);
		send_request('0, '0, '0, 0);
		send_request(32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_F0F0, 0);
		send_request(32'hAAAA_AAAA, 32'h5555_5555, 32'hF0F0_0F0F, 0);
	endtask

	task automatic test_back_to_back();
		run_random(N_RANDOM, 0);
	endtask

	task automatic test_sparse_requests();
		run_random(N_RANDOM, 84);
	endtask

	task automatic test_moderate_gaps();
		run_random(N_RANDOM, 34);
	endtask

	always @(posedge clk) begin
		norm_result_t exp_r;
		if (arst_n && done) begin
			if (pending_norms.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected result: length=%h unit=%h %h %h zero=%b",
						length, x_unit, y_unit, z_unit, zero_vector);
			end else begin
				exp_r = pending_norms.pop_front();
				if (length !== exp_r.len || x_unit !== exp_r.ux || y_unit !== exp_r.uy ||
						z_unit !== exp_r.uz || zero_vector !== exp_r.zero) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("mismatch: exp %h %h %h %h %b, got %h %h %h %h %b",
							exp_r.len, exp_r.ux, exp_r.uy, exp_r.uz, exp_r.zero,
							length, x_unit, y_unit, z_unit, zero_vector);
				end
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		start  = 1'b0;
		x_in   = '0;
		y_in   = '0;
		z_in   = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_back_to_back();
		test_sparse_requests();
		test_moderate_gaps();

		@(negedge clk);
		start = 1'b0;
		while (pending_norms.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
		if (mismatch_count == 0 && pending_norms.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

>>> files.f
rtl/core/vn_pkg.sv
rtl/core/vn_sqrt.sv
rtl/core/vn_div.sv
rtl/core/vector3_normalize.sv
tb/tb_vector3_normalize.sv
